// ----- hdl/differential_pressure_zero_cal_convert_top_assert.svh -----
// assertion macros for the differential pressure zero-cal converter checker
// expects clk and rst_n in the scope of each use
`ifndef DIFFERENTIAL_PRESSURE_ZERO_CAL_CONVERT_TOP_ASSERT_SVH
`define DIFFERENTIAL_PRESSURE_ZERO_CAL_CONVERT_TOP_ASSERT_SVH

// same-cycle implication
`define DPZC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dpzc check failed (same cycle)");

// next-cycle implication
`define DPZC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dpzc check failed (next cycle)");

`endif

// ----- hdl/dpzc_pkg.sv -----
// shared constants and types for the differential pressure zero-cal converter
// no dependencies
package dpzc_pkg;

  localparam int FILTER_SHIFT = 5;
  localparam int PCOUNT_W     = 14;
  localparam int TCOUNT_W     = 11;
  localparam int FILTER_W     = PCOUNT_W + FILTER_SHIFT;
  localparam int CAL_W        = 8;

  localparam logic [CAL_W-1:0] CAL_SAMPLES_RESET = 8'd100;

  // result kinds
  localparam logic [1:0] KIND_MEAS  = 2'd0;
  localparam logic [1:0] KIND_FAULT = 2'd1;
  localparam logic [1:0] KIND_CAL   = 2'd2;

  // pressure scaling, q16 pascals per count
  localparam logic signed [32:0] PRESSURE_SCALE = 33'sd68952;

  // temperature: base + round(num * t / den), den = 2^DEN_SHIFT - 1
  localparam int TEMP_X_W     = 26;
  localparam int TEMP_DEN_SHIFT = 11;
  localparam logic [15:0] TEMP_BASE_CK = 16'd22315;
  localparam logic [15:0] TEMP_MAX_CK  = 16'd42315;
  localparam logic [TEMP_X_W-1:0] TEMP_NUM   = 26'd20000;
  localparam logic [TEMP_X_W-1:0] TEMP_ROUND = 26'd1023;
  localparam logic [11:0] TEMP_DEN = 12'd2047;

  typedef struct packed {
    logic [15:0] temperature_word;
    logic [15:0] pressure_word;
  } frame_t;

endpackage

// ----- hdl/differential_pressure_zero_cal_convert_top.sv -----
// differential pressure converter with zero-offset calibration filter
// depends on dpzc_pkg and dpzc_conv
// pipeline: the input transfer loads the input reg, and the frame moves on into the
// result reg when that is empty or being drained
// throughput: one frame per cycle; the filter update and scaling sit between
// the two registers, so backpressure alone slows it
// reset (rst_n low, synchronous): pipeline empty, uncalibrated, samples reg = 100
module differential_pressure_zero_cal_convert_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // pressure_word[15:0], temperature_word[31:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // sensor_status[1:0], pressure_q16[33:2],
                                  // temperature_centikelvin[49:34], zero[55:50]
  output logic [1:0]  out_tuser,  // result_kind[1:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data    // calibration_samples[7:0]
);

  localparam int FW = dpzc_pkg::FILTER_W;
  localparam int FS = dpzc_pkg::FILTER_SHIFT;
  localparam int PW = dpzc_pkg::PCOUNT_W;

  logic                          s1_valid_r;
  dpzc_pkg::frame_t              s1_frame_r;
  logic                          out_valid_r;
  logic [1:0]                    out_kind_r;
  logic [55:0]                   out_data_r;

  logic [dpzc_pkg::CAL_W-1:0]    cal_samples_r;
  logic                          calibrated_r, calibrated_nxt;
  logic [dpzc_pkg::CAL_W-1:0]    cal_count_r, cal_count_nxt;
  logic [FW-1:0]                 zero_filter_r, zero_filter_nxt;
  logic [PW-1:0]                 zero_offset_r, zero_offset_nxt;

  logic                          advance;
  logic                          fire;
  logic [1:0]                    status;
  logic [PW-1:0]                 p_count;
  logic [dpzc_pkg::TCOUNT_W-1:0] t_count;
  logic [FW-1:0]                 filter_upd;
  logic signed [31:0]            pressure_q16;
  logic [15:0]                   temperature_ck;
  logic [1:0]                    kind_nxt;
  logic [55:0]                   data_nxt;

  assign advance    = !out_valid_r || out_tready;
  assign in_tready  = !s1_valid_r || advance;
  assign fire       = s1_valid_r && advance;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;

  assign status  = s1_frame_r.pressure_word[15:14];
  assign p_count = s1_frame_r.pressure_word[PW-1:0];
  assign t_count = s1_frame_r.temperature_word[15:16-dpzc_pkg::TCOUNT_W];

  dpzc_conv u_conv (
    .p_count        (p_count),
    .t_count        (t_count),
    .zero_offset    (zero_offset_r),
    .pressure_q16   (pressure_q16),
    .temperature_ck (temperature_ck)
  );

  always_comb begin
    filter_upd      = zero_filter_r - (zero_filter_r >> FS) + FW'(p_count);
    calibrated_nxt  = calibrated_r;
    cal_count_nxt   = cal_count_r;
    zero_filter_nxt = zero_filter_r;
    zero_offset_nxt = zero_offset_r;
    kind_nxt        = dpzc_pkg::KIND_MEAS;
    data_nxt        = {6'b0, temperature_ck, pressure_q16, status};
    if (status != 2'b00) begin
      kind_nxt = dpzc_pkg::KIND_FAULT;
      data_nxt = {54'b0, status};
    end else if (!calibrated_r) begin
      kind_nxt = dpzc_pkg::KIND_CAL;
      data_nxt = '0;
      if (cal_count_r == '0) begin
        // seed frame
        zero_filter_nxt = {p_count, {FS{1'b0}}};
        cal_count_nxt   = dpzc_pkg::CAL_W'(1);
      end else begin
        zero_filter_nxt = filter_upd;
        if (cal_count_r >= cal_samples_r) begin
          zero_offset_nxt = filter_upd[FW-1:FS];
          calibrated_nxt  = 1'b1;
          cal_count_nxt   = '0;
        end else begin
          cal_count_nxt = cal_count_r + dpzc_pkg::CAL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      cal_samples_r <= dpzc_pkg::CAL_SAMPLES_RESET;
      calibrated_r  <= 1'b0;
      cal_count_r   <= '0;
      zero_filter_r <= '0;
      zero_offset_r <= '0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
      if (cfg_valid && cfg_ready) begin
        cal_samples_r <= cfg_data;
      end
      if (fire) begin
        calibrated_r  <= calibrated_nxt;
        cal_count_r   <= cal_count_nxt;
        zero_filter_r <= zero_filter_nxt;
        zero_offset_r <= zero_offset_nxt;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_frame_r <= in_tdata;
    end
    if (fire) begin
      out_kind_r <= kind_nxt;
      out_data_r <= data_nxt;
    end
  end

endmodule

// ----- hdl/dpzc_conv.sv -----
// pressure and temperature scaling for one calibrated frame
// depends on dpzc_pkg
module dpzc_conv (
  input  logic [dpzc_pkg::PCOUNT_W-1:0] p_count,
  input  logic [dpzc_pkg::TCOUNT_W-1:0] t_count,
  input  logic [dpzc_pkg::PCOUNT_W-1:0] zero_offset,
  output logic signed [31:0]            pressure_q16,
  output logic [15:0]                   temperature_ck
);

  logic signed [dpzc_pkg::PCOUNT_W:0] diff;
  logic signed [32:0]                 diff_ext;
  logic signed [32:0]                 prod;
  logic [dpzc_pkg::TEMP_X_W-1:0]      tx;
  logic [14:0]                        hi;
  logic [10:0]                        lo;
  logic [15:0]                        r1;
  logic [11:0]                        r2;
  logic                               corr;
  logic [14:0]                        quot;

  always_comb begin
    diff     = $signed({1'b0, p_count}) - $signed({1'b0, zero_offset});
    diff_ext = {{(33 - dpzc_pkg::PCOUNT_W - 1){diff[dpzc_pkg::PCOUNT_W]}}, diff};
    prod     = diff_ext * dpzc_pkg::PRESSURE_SCALE;
    pressure_q16 = prod[31:0];
  end

  // divide by 2047 using 2048 = 2047 + 1: fold the high part back twice,
  // then one compare that adds a final correction of one to the quotient
  always_comb begin
    tx   = dpzc_pkg::TEMP_X_W'(t_count) * dpzc_pkg::TEMP_NUM + dpzc_pkg::TEMP_ROUND;
    hi   = tx[dpzc_pkg::TEMP_X_W-1:dpzc_pkg::TEMP_DEN_SHIFT];
    lo   = tx[dpzc_pkg::TEMP_DEN_SHIFT-1:0];
    r1   = {1'b0, hi} + {5'b0, lo};
    r2   = {7'b0, r1[15:11]} + {1'b0, r1[10:0]};
    corr = (r2 >= dpzc_pkg::TEMP_DEN);
    quot = hi + {10'b0, r1[15:11]} + {14'b0, corr};
    temperature_ck = dpzc_pkg::TEMP_BASE_CK + {1'b0, quot};
  end

endmodule

// ----- hdl/dpzc_checker.sv -----
// port-level checker for the differential pressure zero-cal converter, with bind
// depends on dpzc_pkg and differential_pressure_zero_cal_convert_top_assert.svh
`include "differential_pressure_zero_cal_convert_top_assert.svh"

module dpzc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata,
  input logic [1:0]  out_tuser
);

  logic        out_stall;
  logic [1:0]  status;
  logic [15:0] temp_ck;
  logic        is_fault;
  logic        is_meas;
  logic        temp_ok;

  assign out_stall = out_tvalid && !out_tready;
  assign status    = out_tdata[1:0];
  assign temp_ck   = out_tdata[49:34];
  assign is_fault  = (out_tuser == dpzc_pkg::KIND_FAULT);
  assign is_meas   = (out_tuser == dpzc_pkg::KIND_MEAS);
  assign temp_ok   = (temp_ck >= dpzc_pkg::TEMP_BASE_CK) && (temp_ck <= dpzc_pkg::TEMP_MAX_CK);

  // held result must not change until its transfer
  `DPZC_ASSERT_NEXT(a_out_hold, out_stall, out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  // input side stalls only when a result is stuck
  `DPZC_ASSERT_SAME(a_in_stall, !in_tready, out_stall)

  // fault kind exactly when status is nonzero
  `DPZC_ASSERT_SAME(a_fault_status, out_tvalid, is_fault == (status != 2'b00))

  // non-measurement results carry zero pressure and temperature
  `DPZC_ASSERT_SAME(a_zero_payload, out_tvalid && !is_meas, out_tdata[55:2] == '0)

  // measured temperature stays in its range
  `DPZC_ASSERT_SAME(a_temp_range, out_tvalid && is_meas, temp_ok)

endmodule

bind differential_pressure_zero_cal_convert_top dpzc_checker u_dpzc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
